// ===== rtl/core/ors_pkg.sv =====
`default_nettype none
package ors_pkg;

   // opcodes of an input item
   localparam logic [2:0] OP_ADD        = 3'd0;
   localparam logic [2:0] OP_REMOVE     = 3'd1;
   localparam logic [2:0] OP_CONTAINS   = 3'd2;
   localparam logic [2:0] OP_MERGE_LIVE = 3'd3;
   localparam logic [2:0] OP_MERGE_TOMB = 3'd4;
   localparam logic [2:0] OP_LIST       = 3'd5;

   // default sizes
   localparam int LIVE_ENTRIES_DEF = 16;
   localparam int TOMB_ENTRIES_DEF = 64;
   localparam int ELEM_BITS_DEF    = 32;
   localparam int TAG_BITS_DEF     = 32;

   // a list run gives at most this many items
   localparam int LIST_MAX = 16;

   // port field widths
   localparam int OP_W    = 3;
   localparam int FIELD_W = 32;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 40;

   // per-cell control
   typedef struct packed {
      logic load;    // take the new pair
      logic shift;   // take the pair of the next cell up
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/core/ors_live_cell.sv =====
`default_nettype none
module ors_live_cell #(
   parameter int ELEM_BITS = 32,
   parameter int TAG_BITS  = 32
) (
   input  wire                      clock,
   input  wire ors_pkg::cell_ctl_type ctl,
   input  wire  [ELEM_BITS-1:0]     new_elem,
   input  wire  [TAG_BITS-1:0]      new_tag,
   input  wire  [ELEM_BITS-1:0]     nb_elem,
   input  wire  [TAG_BITS-1:0]      nb_tag,
   input  wire  [ELEM_BITS-1:0]     key_elem,
   input  wire  [TAG_BITS-1:0]      key_tag,
   output logic [ELEM_BITS-1:0]     elem,
   output logic [TAG_BITS-1:0]      tag,
   output logic                     eq_elem,
   output logic                     eq_pair
);
   import ors_pkg::*;

   logic [ELEM_BITS-1:0] elem_ff;
   logic [TAG_BITS-1:0]  tag_ff;

   // payload: load beats shift, otherwise hold
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         elem_ff <= new_elem;
         tag_ff  <= new_tag;
      end else if (ctl.shift) begin
         elem_ff <= nb_elem;
         tag_ff  <= nb_tag;
      end
   end

   // compare against the key
   assign eq_elem = (elem_ff == key_elem);
   assign eq_pair = eq_elem && (tag_ff == key_tag);
   assign elem    = elem_ff;
   assign tag     = tag_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ors_tomb_cell.sv =====
`default_nettype none
module ors_tomb_cell #(
   parameter int ELEM_BITS = 32,
   parameter int TAG_BITS  = 32
) (
   input  wire                      clock,
   input  wire                      load,
   input  wire  [ELEM_BITS-1:0]     key_elem,
   input  wire  [TAG_BITS-1:0]      key_tag,
   output logic                     eq_pair
);
   import ors_pkg::*;

   logic [ELEM_BITS-1:0] elem_ff;
   logic [TAG_BITS-1:0]  tag_ff;

   // the key is also the pair written on load
   always_ff @(posedge clock) begin
      if (load) begin
         elem_ff <= key_elem;
         tag_ff  <= key_tag;
      end
   end

   assign eq_pair = (elem_ff == key_elem) && (tag_ff == key_tag);

endmodule
`default_nettype wire

// ===== rtl/core/observed_remove_set_engine_unit.sv =====
`default_nettype none
// channel | dir | handshake                    | payload
// req     | in  | req_tvalid / req_tready      | req_tdata: op, elem, tag
// rsp     | out | rsp_tvalid / rsp_tready      | rsp_tdata: found, elem_out, empty_res,
//         |     |                              |   overflow; rsp_tlast: last
// An item is taken in the idle state and executed in the next cycle against a
// row of cells that compare the key in parallel; add, contains and merge then
// register their result and wait for the result handshake. Remove instead
// takes the live pairs of the element one at a time, each tombstoned (a full
// tomb row sets overflow instead) and compacted out of the row.
// List gives one result per cycle while rsp_tready is high, counting over the live row.
// Reset clears the counts and the control; stalled results hold in rsp_tdata.
module observed_remove_set_engine_unit #(
   parameter int LIVE_ENTRIES = ors_pkg::LIVE_ENTRIES_DEF,
   parameter int TOMB_ENTRIES = ors_pkg::TOMB_ENTRIES_DEF,
   parameter int ELEM_BITS    = ors_pkg::ELEM_BITS_DEF,
   parameter int TAG_BITS     = ors_pkg::TAG_BITS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   // [2:0] op, [34:3] elem, [66:35] tag, [71:67] zero
   input  wire  [ors_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   // [0] found, [32:1] elem_out, [33] empty_res, [34] overflow, [39:35] zero
   output logic [ors_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tlast
);
   import ors_pkg::*;

   localparam int LIVE_CW = $clog2(LIVE_ENTRIES + 1);
   localparam int LIVE_IW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
   localparam int TOMB_CW = $clog2(TOMB_ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_REMOVE, S_LIST, S_DRAIN
   } state_type;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [ELEM_BITS-1:0]  key_elem_ff, key_elem_in;
   logic [TAG_BITS-1:0]   key_tag_ff, key_tag_in;
   logic [LIVE_CW-1:0]    live_count_ff, live_count_in;
   logic [TOMB_CW-1:0]    tomb_count_ff, tomb_count_in;
   logic [LIVE_IW-1:0]    list_ff, list_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic [FIELD_W-1:0]    elem_out_ff, elem_out_in;
   logic                  empty_ff, empty_in;
   logic                  ovf_out_ff, ovf_out_in;
   logic                  last_ff, last_in;

   // live row
   logic [ELEM_BITS-1:0]  live_elem [LIVE_ENTRIES];
   logic [TAG_BITS-1:0]   live_tag  [LIVE_ENTRIES];
   logic [LIVE_ENTRIES-1:0] eq_elem, eq_pair, hit_elem, hit_pair;
   cell_ctl_type          live_ctl [LIVE_ENTRIES];
   // tombstone row
   logic [TOMB_ENTRIES-1:0] tomb_eq, tomb_hit, tomb_load;
   logic [TAG_BITS-1:0]   tomb_key_tag;

   logic                  any_elem, any_pair, tomb_any;
   logic [LIVE_IW-1:0]    idx_elem, idx_pair, del_idx;
   logic                  live_load, live_shift, tomb_wr;
   logic                  live_full, tomb_full;

   // input fields
   logic [OP_W-1:0]       req_op;
   logic [ELEM_BITS-1:0]  req_elem;
   logic [TAG_BITS-1:0]   req_tag;
   assign req_op   = req_tdata[2:0];
   assign req_elem = ELEM_BITS'(req_tdata[34:3]);
   assign req_tag  = TAG_BITS'(req_tdata[66:35]);

   // cells
   for (genvar i = 0; i < LIVE_ENTRIES; i++) begin : g_live
      logic [ELEM_BITS-1:0] nb_e;
      logic [TAG_BITS-1:0]  nb_t;
      if (i == LIVE_ENTRIES - 1) begin : g_top
         assign nb_e = live_elem[i];
         assign nb_t = live_tag[i];
      end else begin : g_mid
         assign nb_e = live_elem[i+1];
         assign nb_t = live_tag[i+1];
      end
      ors_live_cell #(.ELEM_BITS(ELEM_BITS), .TAG_BITS(TAG_BITS)) u_cell (
         .clock(clock), .ctl(live_ctl[i]),
         .new_elem(key_elem_ff), .new_tag(key_tag_ff),
         .nb_elem(nb_e), .nb_tag(nb_t),
         .key_elem(key_elem_ff), .key_tag(key_tag_ff),
         .elem(live_elem[i]), .tag(live_tag[i]),
         .eq_elem(eq_elem[i]), .eq_pair(eq_pair[i])
      );
   end

   for (genvar j = 0; j < TOMB_ENTRIES; j++) begin : g_tomb
      ors_tomb_cell #(.ELEM_BITS(ELEM_BITS), .TAG_BITS(TAG_BITS)) u_cell (
         .clock(clock), .load(tomb_load[j]),
         .key_elem(key_elem_ff), .key_tag(tomb_key_tag),
         .eq_pair(tomb_eq[j])
      );
   end

   // hits gated by occupancy, first-hit encoders
   always_comb begin
      idx_elem = '0;
      idx_pair = '0;
      for (int i = LIVE_ENTRIES - 1; i >= 0; i--) begin
         hit_elem[i] = eq_elem[i] && (LIVE_CW'(i) < live_count_ff);
         hit_pair[i] = eq_pair[i] && (LIVE_CW'(i) < live_count_ff);
         if (hit_elem[i]) idx_elem = LIVE_IW'(i);
         if (hit_pair[i]) idx_pair = LIVE_IW'(i);
      end
      for (int j = 0; j < TOMB_ENTRIES; j++) begin
         tomb_hit[j] = tomb_eq[j] && (TOMB_CW'(j) < tomb_count_ff);
      end
   end

   assign any_elem  = |hit_elem;
   assign any_pair  = |hit_pair;
   assign tomb_any  = |tomb_hit;
   assign live_full = (live_count_ff == LIVE_CW'(LIVE_ENTRIES));
   assign tomb_full = (tomb_count_ff == TOMB_CW'(TOMB_ENTRIES));
   // remove tombstones the matched live pair
   assign tomb_key_tag = (state_ff == S_REMOVE) ? live_tag[idx_elem] : key_tag_ff;
   assign del_idx      = (state_ff == S_REMOVE) ? idx_elem : idx_pair;

   // row control
   always_comb begin
      live_load  = 1'b0;
      live_shift = 1'b0;
      tomb_wr    = 1'b0;
      if (state_ff == S_EXEC) begin
         if ((op_ff == OP_ADD || op_ff == OP_MERGE_LIVE) && !any_pair && !tomb_any
             && !live_full) live_load = 1'b1;
         if (op_ff == OP_MERGE_TOMB) begin
            live_shift = any_pair;
            tomb_wr    = !tomb_any && !tomb_full;
         end
      end else if (state_ff == S_REMOVE && any_elem) begin
         live_shift = 1'b1;
         tomb_wr    = !tomb_any && !tomb_full;
      end
      for (int i = 0; i < LIVE_ENTRIES; i++) begin
         live_ctl[i].load  = live_load && (live_count_ff == LIVE_CW'(i));
         live_ctl[i].shift = live_shift && (LIVE_CW'(i) >= LIVE_CW'(del_idx));
      end
      for (int j = 0; j < TOMB_ENTRIES; j++) begin
         tomb_load[j] = tomb_wr && (tomb_count_ff == TOMB_CW'(j));
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_elem_in   = key_elem_ff;
      key_tag_in    = key_tag_ff;
      live_count_in = live_count_ff + LIVE_CW'(live_load) - LIVE_CW'(live_shift);
      tomb_count_in = tomb_count_ff + TOMB_CW'(tomb_wr);
      list_in       = list_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff;
      found_in      = found_ff;
      elem_out_in   = elem_out_ff;
      empty_in      = empty_ff;
      ovf_out_in    = ovf_out_ff;
      last_in       = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_op;
               key_elem_in = req_elem;
               key_tag_in  = req_tag;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_valid_in = 1'b1;
            found_in     = 1'b0;
            elem_out_in  = '0;
            empty_in     = 1'b0;
            ovf_out_in   = 1'b0;
            last_in      = 1'b1;
            state_in     = S_DRAIN;
            case (op_ff)
               OP_ADD, OP_MERGE_LIVE: ovf_out_in = !any_pair && !tomb_any && live_full;
               OP_CONTAINS:           found_in   = any_elem;
               OP_MERGE_TOMB:         ovf_out_in = !tomb_any && tomb_full;
               OP_REMOVE: begin
                  rsp_valid_in = 1'b0;
                  ovf_in       = 1'b0;
                  state_in     = S_REMOVE;
               end
               OP_LIST: begin
                  if (live_count_ff == '0) begin
                     empty_in = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b0;
                     list_in      = '0;
                     state_in     = S_LIST;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_REMOVE: begin
            if (any_elem) begin
               if (!tomb_any && tomb_full) ovf_in = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               elem_out_in  = '0;
               empty_in     = 1'b0;
               ovf_out_in   = ovf_ff;
               last_in      = 1'b1;
               state_in     = S_DRAIN;
            end
         end
         S_LIST: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               elem_out_in  = FIELD_W'(live_elem[list_ff]);
               empty_in     = 1'b0;
               ovf_out_in   = 1'b0;
               last_in      = (LIVE_CW'(list_ff) + LIVE_CW'(1) == live_count_ff)
                              || (int'(list_ff) == LIST_MAX - 1);
               list_in      = list_ff + LIVE_IW'(1);
               if (last_in) state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_count_ff <= '0;
         tomb_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         ovf_ff        <= 1'b0;
         list_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         live_count_ff <= live_count_in;
         tomb_count_ff <= tomb_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         ovf_ff        <= ovf_in;
         list_ff       <= list_in;
      end
      op_ff       <= op_in;
      key_elem_ff <= key_elem_in;
      key_tag_ff  <= key_tag_in;
      found_ff    <= found_in;
      elem_out_ff <= elem_out_in;
      empty_ff    <= empty_in;
      ovf_out_ff  <= ovf_out_in;
      last_ff     <= last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {5'd0, ovf_out_ff, empty_ff, elem_out_ff, found_ff};

   // checks
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= LIVE_CW'(LIVE_ENTRIES)) else $error("live count overrun");
   a_tomb_bound: assert property (@(posedge clock) disable iff (reset)
      tomb_count_ff <= TOMB_CW'(TOMB_ENTRIES)) else $error("tomb count overrun");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("result pending while idle");
   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REMOVE |=> live_count_ff <= $past(live_count_ff))
      else $error("remove grew live row");

endmodule
`default_nettype wire
